>>> rtl/tcm_pkg.sv
// Shared types and constants for the tagged cell memory.
// Cell layout, operation and status codes, and sizing constants.
// No dependencies.
package tcm_pkg;

  localparam int MAX_ORDER  = 16;
  localparam int CELL_DEPTH = 1 << MAX_ORDER;
  localparam int CELL_AW    = MAX_ORDER;
  localparam int ADDR_W     = 16;
  localparam int ORDER_W    = 5;
  localparam int OP_W       = 3;
  localparam int INST_W     = 6;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 17;

  localparam logic [OP_W-1:0] OP_READ      = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE     = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_START = 3'd2;
  localparam logic [OP_W-1:0] OP_CLR_START = 3'd3;
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd4;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PRECOND = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd16;

  typedef struct packed {
    logic              start;
    logic              used;
    logic [INST_W-1:0] inst;
  } cell_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    cell_t               data;
    logic                used_inc;
    logic                used_dec;
    logic                start_inc;
    logic                start_dec;
  } alu_res_t;

endpackage

>>> rtl/tagged_cell_memory_with_occupancy_top.sv
// Top level of the tagged cell memory: clearing sweep, read-modify-write
// pipeline with forwarding, occupancy counters and output register.
// Depends on tcm_pkg, tcm_ram and tcm_cell_alu.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | op, addr, inst_in
//  out      | out_valid / out_stall| status, inst_out, is_block_start, is_used,
//           |                      | used_total, start_total, over_cap
//  cfg      | cfg_we               | cfg_wdata (mem_order)
//
// One word per cycle unless the sweep or out_stall holds it; the edge that
// takes a word reads its cell, the edge that retires it from s1 modifies it,
// writes it back and registers the result. A write back to the address read
// at the same edge is forwarded. After reset a sweep clears the 65536 cells
// with in_stall high; configuration writes are taken at any time. A stalled
// result is held, and in_stall rises once a second word waits behind it.
module tagged_cell_memory_with_occupancy_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcm_pkg::OP_W-1:0]     op,
  input  logic [tcm_pkg::ADDR_W-1:0]   addr,
  input  logic [tcm_pkg::INST_W-1:0]   inst_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcm_pkg::STATUS_W-1:0] status,
  output logic [tcm_pkg::INST_W-1:0]   inst_out,
  output logic                         is_block_start,
  output logic                         is_used,
  output logic [tcm_pkg::COUNT_W-1:0]  used_total,
  output logic [tcm_pkg::COUNT_W-1:0]  start_total,
  output logic                         over_cap,
  input  logic                         cfg_we,
  input  logic [tcm_pkg::ORDER_W-1:0]  cfg_wdata
);
  import tcm_pkg::*;

  logic [ORDER_W-1:0] mem_order;
  logic [ORDER_W-1:0] live_order;
  logic [COUNT_W-1:0] size;

  logic               clearing;
  logic [CELL_AW-1:0] clr_addr;

  logic               s1_valid;
  logic [OP_W-1:0]    s1_op;
  logic [ADDR_W-1:0]  s1_addr;
  logic [INST_W-1:0]  s1_inst;
  logic               s1_in_range;
  logic               fwd;
  cell_t              fwd_cell;

  logic [COUNT_W-1:0] used_count;
  logic [COUNT_W-1:0] start_count;
  logic [COUNT_W-1:0] used_next;
  logic [COUNT_W-1:0] start_next;

  logic               accept;
  logic               s1_done;
  logic               s1_wr;
  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  cell_t              cur_cell;
  alu_res_t           alu_res;

  always_comb begin
    live_order = mem_order;
    if (mem_order == '0) begin
      live_order = ORDER_W'(1);
    end else if (mem_order > ORDER_W'(MAX_ORDER)) begin
      live_order = ORDER_W'(MAX_ORDER);
    end
  end

  assign size     = COUNT_W'(1) << live_order;
  assign s1_done  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = clearing || (s1_valid && !s1_done);
  assign accept   = in_valid && !in_stall;
  assign s1_wr    = s1_done && s1_in_range;
  assign cur_cell = fwd ? fwd_cell : cell_t'(ram_rdata);

  assign ram_we    = clearing || s1_wr;
  assign ram_waddr = clearing ? clr_addr : s1_addr[CELL_AW-1:0];
  assign ram_wdata = clearing ? 8'd0 : 8'(alu_res.data);

  tcm_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELL_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (addr[CELL_AW-1:0]),
    .rdata (ram_rdata)
  );

  tcm_cell_alu u_alu (
    .op          (s1_op),
    .inst        (s1_inst),
    .in_range    (s1_in_range),
    .cur         (cur_cell),
    .used_count  (used_count),
    .start_count (start_count),
    .res         (alu_res)
  );

  assign used_next  = used_count + COUNT_W'(alu_res.used_inc) - COUNT_W'(alu_res.used_dec);
  assign start_next = start_count + COUNT_W'(alu_res.start_inc)
                      - COUNT_W'(alu_res.start_dec);

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_order   <= ORDER_RESET;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      s1_valid    <= 1'b0;
      fwd         <= 1'b0;
      used_count  <= '0;
      start_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        mem_order <= cfg_wdata;
      end
      if (clearing) begin
        clr_addr <= clr_addr + CELL_AW'(1);
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid    <= 1'b1;
        s1_op       <= op;
        s1_addr     <= addr;
        s1_inst     <= inst_in;
        s1_in_range <= {1'b0, addr} < size;
        fwd         <= s1_wr && (s1_addr == addr);
        fwd_cell    <= alu_res.data;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end
      if (s1_done) begin
        used_count     <= used_next;
        start_count    <= start_next;
        out_valid      <= 1'b1;
        status         <= alu_res.status;
        inst_out       <= alu_res.data.inst;
        is_block_start <= alu_res.data.start;
        is_used        <= alu_res.data.used;
        used_total     <= used_next;
        start_total    <= start_next;
        over_cap       <= used_next > (size >> 1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !out_valid)
    else $error("word in flight during clearing sweep");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (used_count == $past(used_count) ||
                     used_count == $past(used_count) + COUNT_W'(1) ||
                     used_count == $past(used_count) - COUNT_W'(1)))
    else $error("used count moved by more than one");

  a_start_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (start_count == $past(start_count) ||
                     start_count == $past(start_count) + COUNT_W'(1) ||
                     start_count == $past(start_count) - COUNT_W'(1)))
    else $error("start count moved by more than one");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RANGE |-> inst_out == '0 && !is_used && !is_block_start)
    else $error("out of range result carries cell contents");
`endif

endmodule

>>> rtl/tcm_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read during write to the same address returns the old data.
// No dependencies.
module tcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tcm_cell_alu.sv
// Applies one operation to one cell word and checks its precondition.
// Returns the new cell, the status and the count adjustments.
// Depends on tcm_pkg.
module tcm_cell_alu (
  input  logic [tcm_pkg::OP_W-1:0]    op,
  input  logic [tcm_pkg::INST_W-1:0]  inst,
  input  logic                        in_range,
  input  tcm_pkg::cell_t              cur,
  input  logic [tcm_pkg::COUNT_W-1:0] used_count,
  input  logic [tcm_pkg::COUNT_W-1:0] start_count,
  output tcm_pkg::alu_res_t           res
);
  import tcm_pkg::*;

  always_comb begin
    res        = '0;
    res.status = ST_DONE;
    res.data   = cur;
    if (!in_range) begin
      res.status = ST_RANGE;
      res.data   = '0;
    end else begin
      unique case (op)
        OP_READ: begin
          res.data = cur;
        end
        OP_WRITE: begin
          res.data.inst = inst;
        end
        OP_SET_START: begin
          if (cur.start) begin
            res.status = ST_PRECOND;
          end else begin
            res.data.start = 1'b1;
            res.start_inc  = 1'b1;
          end
        end
        OP_CLR_START: begin
          if (!cur.start || start_count == '0) begin
            res.status = ST_PRECOND;
          end else begin
            res.data.start = 1'b0;
            res.start_dec  = 1'b1;
          end
        end
        OP_ALLOC: begin
          if (cur.used) begin
            res.status = ST_PRECOND;
          end else begin
            res.data.used = 1'b1;
            res.used_inc  = 1'b1;
          end
        end
        OP_FREE: begin
          if (!cur.used || used_count == '0) begin
            res.status = ST_PRECOND;
          end else begin
            res.data.used = 1'b0;
            res.used_dec  = 1'b1;
          end
        end
        default: begin
          res.status = ST_PRECOND;
        end
      endcase
    end
  end

endmodule
